// File: sv/can_servo_pwm_gateway_unit_assert.svh
`ifndef CAN_SERVO_PWM_GATEWAY_UNIT_ASSERT_SVH
`define CAN_SERVO_PWM_GATEWAY_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define CSG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/csg_pkg.sv
package csg_pkg;

  localparam int WIDTH_W    = 12;
  localparam int TIME_W     = 16;
  localparam int ID_W       = 11;
  localparam int SUM_W      = 14;
  localparam int SCALE_W    = 33;
  localparam int PROD_W     = 41;
  localparam int RECIP_SHIFT = 28;

  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [ID_W-1:0]    frame_id_t;
  typedef logic [SCALE_W-1:0] scale_t;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic {
    RES_PINS = 1'b0,
    RES_ACK  = 1'b1
  } res_kind_t;

  typedef enum logic [3:0] {
    REG_MIN_PULSE  = 4'd0,
    REG_MAX_PULSE  = 4'd1,
    REG_PERIOD     = 4'd2,
    REG_COMMAND_ID = 4'd3
  } cfg_reg_t;

  // input word, lowest field last
  typedef struct packed {
    logic       spare;
    logic [15:0] angle;
    logic [7:0]  channel;
    logic [3:0]  frame_len;
    frame_id_t   frame_id;
  } in_word_t;

  // result word, lowest field last
  typedef struct packed {
    logic [2:0] spare;
    logic [3:0] pins;
    logic       ack_ok;
  } out_word_t;

  localparam logic [7:0]  MAX_ANGLE      = 8'd180;
  localparam logic [3:0]  MIN_DATA_BYTES = 4'd3;
  localparam width_t      RESET_WIDTH    = 12'd1500;
  localparam width_t      RESET_MIN      = 12'd1000;
  localparam width_t      RESET_MAX      = 12'd2000;
  localparam time_t       RESET_PERIOD   = 16'd20000;
  localparam frame_id_t   RESET_CMD_ID   = 11'h430;

  // ceil(2^28 / 180): exact floor division for products below 2^28 / 164
  localparam logic [20:0] RECIP_MULT = 21'd1491309;
  localparam scale_t RESET_SCALE =
    SCALE_W'(64'(RESET_MAX - RESET_MIN) * 64'(RECIP_MULT));

endpackage

// File: sv/can_servo_pwm_gateway_unit.sv
// Four-channel servo pulse generator fed by command frames and microsecond ticks.
// Input channel in_*: tuser is the op (0 command frame, 1 tick), tdata carries
// frame_id, frame_len, channel and angle. A command whose id matches command_id
// yields one ack word (ok, or fail for short frame / bad channel); other ids
// yield nothing. Every tick yields one word with the four pin levels.
// Result channel out_*: tuser is 1 for an ack, 0 for pin levels.
// Configuration channel cfg_*: index 0 min pulse, 1 max pulse, 2 period,
// 3 command id; always ready, write only while no item is in flight.
// A word with a result passes the input register, then the result register, before
// out_tvalid rises; one word per cycle is taken back to back while out_tready is high.
// The pulse is computed with one multiply by a reciprocal of 180 held
// pre-scaled with the span, so every item finishes in a single pass.
// Reset restores the register defaults, 1500 us widths and frame position 0.
// When the receiver stalls the result register holds; the input register
// still takes one word, then in_tready drops until out_tready returns.
`include "can_servo_pwm_gateway_unit_assert.svh"

module can_servo_pwm_gateway_unit
  import csg_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // frame_id[10:0], frame_len[14:11], channel[22:15], angle[38:23]
  input  logic        in_tuser,   // op[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // ack_ok[0], pins[4:1]
  output logic        out_tuser,  // is_ack[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration
  width_t    min_r, min_nxt;
  width_t    max_r, max_nxt;
  time_t     period_r, period_nxt;
  frame_id_t cmd_id_r, cmd_id_nxt;
  scale_t    scale_r, scale_nxt;
  width_t    span_c;

  // input stage
  logic     in_vld_r;
  op_t      in_op_r;
  in_word_t in_word_r;

  // block state
  width_t pw_r [CHANNELS];
  width_t aw_r [CHANNELS];
  time_t  frame_time_r, frame_time_nxt;

  // result stage
  logic      out_vld_r;
  res_kind_t out_kind_r;
  out_word_t out_word_r;

  logic              out_free;
  logic              adv;
  logic              is_tick;
  logic              id_match;
  logic              cmd_ok;
  logic              has_res;
  logic [7:0]        deg_c;
  logic [PROD_W-1:0] prod_c;
  width_t            new_width;
  logic              ft_zero;
  width_t            w_c   [CHANNELS];
  logic [SUM_W-1:0]  sum_c [CHANNELS+1];
  logic [3:0]        pins_c;
  time_t             sum16_c;
  time_t             total_c;
  logic [TIME_W:0]   ft_inc;

  assign cfg_ready = 1'b1;

  always_comb begin
    min_nxt    = min_r;
    max_nxt    = max_r;
    period_nxt = period_r;
    cmd_id_nxt = cmd_id_r;
    if (cfg_valid) begin
      case (cfg_addr)
        REG_MIN_PULSE:  min_nxt    = cfg_data[WIDTH_W-1:0];
        REG_MAX_PULSE:  max_nxt    = cfg_data[WIDTH_W-1:0];
        REG_PERIOD:     period_nxt = cfg_data;
        REG_COMMAND_ID: cmd_id_nxt = cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
    span_c    = (max_nxt > min_nxt) ? (max_nxt - min_nxt) : '0;
    scale_nxt = SCALE_W'(span_c) * SCALE_W'(RECIP_MULT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= RESET_MIN;
      max_r    <= RESET_MAX;
      period_r <= RESET_PERIOD;
      cmd_id_r <= RESET_CMD_ID;
      scale_r  <= RESET_SCALE;
    end else begin
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      period_r <= period_nxt;
      cmd_id_r <= cmd_id_nxt;
      scale_r  <= scale_nxt;
    end
  end

  // handshake
  assign out_free  = !out_vld_r || out_tready;
  assign adv       = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r   <= op_t'(in_tuser);
      in_word_r <= in_word_t'(in_tdata);
    end
  end

  // command path
  always_comb begin
    is_tick  = (in_op_r == OP_TICK);
    id_match = (in_word_r.frame_id == cmd_id_r);
    cmd_ok   = (in_word_r.frame_len >= MIN_DATA_BYTES) &&
               (int'(in_word_r.channel) < CHANNELS);
    has_res  = is_tick || id_match;
    deg_c    = (in_word_r.angle > 16'(MAX_ANGLE)) ? MAX_ANGLE : in_word_r.angle[7:0];
    prod_c   = PROD_W'(scale_r) * PROD_W'(deg_c);
    new_width = min_r + prod_c[RECIP_SHIFT +: WIDTH_W];
  end

  // tick path: widths latch at frame start, channels pulse in turn
  always_comb begin
    ft_zero  = (frame_time_r == '0);
    sum_c[0] = '0;
    pins_c   = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      w_c[i]     = ft_zero ? pw_r[i] : aw_r[i];
      sum_c[i+1] = sum_c[i] + SUM_W'(w_c[i]);
      pins_c[i]  = (TIME_W'(sum_c[i]) <= frame_time_r) &&
                   (frame_time_r < TIME_W'(sum_c[i+1]));
    end
    sum16_c = TIME_W'(sum_c[CHANNELS]);
    total_c = (period_r > sum16_c) ? period_r : sum16_c;
    if (total_c == '0) begin
      total_c = TIME_W'(1);
    end
    ft_inc         = {1'b0, frame_time_r} + (TIME_W+1)'(1);
    frame_time_nxt = (ft_inc >= {1'b0, total_c}) ? '0 : ft_inc[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_time_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pw_r[i] <= RESET_WIDTH;
        aw_r[i] <= RESET_WIDTH;
      end
    end else if (adv) begin
      if (is_tick) begin
        frame_time_r <= frame_time_nxt;
        if (ft_zero) begin
          for (int i = 0; i < CHANNELS; i++) begin
            aw_r[i] <= pw_r[i];
          end
        end
      end else if (id_match && cmd_ok) begin
        pw_r[in_word_r.channel[CIW-1:0]] <= new_width;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= has_res;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_res) begin
      out_kind_r        <= is_tick ? RES_PINS : RES_ACK;
      out_word_r.spare  <= '0;
      out_word_r.ack_ok <= !is_tick && cmd_ok;
      out_word_r.pins   <= is_tick ? pins_c : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_word_r;

  `CSG_ASSERT_SAME(a_pins_onehot, out_vld_r && (out_kind_r == RES_PINS), $onehot0(out_word_r.pins), "more than one servo pin high")
  `CSG_ASSERT_SAME(a_ack_no_pins, out_vld_r && (out_kind_r == RES_ACK), out_word_r.pins == '0, "ack word carries pin levels")
  `CSG_ASSERT_NEXT(a_silent_item, adv && !has_res, !out_vld_r, "result shown for an unmatched frame")
  `CSG_ASSERT_SAME(a_no_stall, in_vld_r && !out_vld_r, in_tready, "input held back with result stage empty")

endmodule
